// ===== sv/stb_pkg.sv =====
// shared types and constants for the sv39 table builder
`default_nettype none

package stb_pkg;

  localparam int unsigned PPN_W   = 44;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned VA_W    = 39;
  localparam int unsigned FLAGS_W = 10;
  localparam int unsigned PTE_W   = 64;

  localparam logic [PPN_W-1:0]   BASE_PPN_RESET = 44'h000_0008_0000;
  localparam logic [IDX_W-1:0]   DEV_SLOT       = 9'd0;
  localparam logic [IDX_W-1:0]   RAM_SLOT       = 9'd2;
  localparam logic [PTE_W-1:0]   DEV_GIG_PTE    = 64'h0000_0000_0000_00CF;
  localparam logic [PTE_W-1:0]   RAM_GIG_PTE    = 64'h0000_0000_2000_00CF;
  localparam logic [FLAGS_W-1:0] PTR_FLAGS      = 10'h001;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OUTSIDE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EV2, S_RD1, S_EV1, S_ZMID, S_LMID,
    S_ZLOW, S_LLOW, S_LEAF, S_CZERO, S_CDEV, S_CRAM, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MEM_NONE, MEM_RD, MEM_WR
  } mem_op_t;

  typedef enum logic [2:0] {
    A_ROOT_I2, A_MID_I1, A_LOW_I0, A_SWEEP, A_DEV, A_RAM
  } addr_sel_t;

  typedef enum logic [2:0] {
    W_ZERO, W_PTR, W_LEAF, W_DEV, W_RAM
  } wdata_sel_t;

  typedef struct packed {
    logic        func;
    logic [3:0]  root_page;
    logic [VA_W-1:0]    virt_addr;
    logic [PPN_W-1:0]   target_ppn;
    logic [FLAGS_W-1:0] leaf_flags;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] page_index;
    logic [4:0] pages_used;
  } result_t;

  typedef struct packed {
    logic       load_item;
    mem_op_t    mem_op;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       mid_from_entry;
    logic       low_from_entry;
    logic       mid_new;
    logic       low_new;
    logic       page_alloc;
    logic       out_load;
    status_t    out_status;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic root_ok;
    logic pool_full;
    logic free_ge2;
    logic e_valid;
    logic e_ok;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/stb_req_if.sv =====
// request channel interface
`default_nettype none

interface stb_req_if;
  import stb_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [3:0]          root_page;
  logic [VA_W-1:0]     virt_addr;
  logic [PPN_W-1:0]    target_ppn;
  logic [FLAGS_W-1:0]  leaf_flags;

  modport source (output valid, func, root_page, virt_addr, target_ppn, leaf_flags,
                  input ready);
  modport sink   (input valid, func, root_page, virt_addr, target_ppn, leaf_flags,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/stb_rsp_if.sv =====
// result channel interface
`default_nettype none

interface stb_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] page_index;
  logic [4:0] pages_used;

  modport source (output valid, status, page_index, pages_used, input ready);
  modport sink   (input valid, status, page_index, pages_used, output ready);
endinterface

`default_nettype wire

// ===== sv/stb_ctrl.sv =====
// sequencing state machine for table creation and page mapping
`default_nettype none

module stb_ctrl
  import stb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mem_op     = MEM_NONE;
    cmd.addr_sel   = A_ROOT_I2;
    cmd.wdata_sel  = W_ZERO;
    cmd.out_status = code_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts.func) begin
          if (sts.pool_full) begin
            code_nxt  = ST_EXHAUSTED;
            state_nxt = S_DONE;
          end else begin
            cmd.sweep_clr = 1'b1;
            state_nxt     = S_CZERO;
          end
        end else if (!sts.root_ok) begin
          code_nxt  = ST_OUTSIDE;
          state_nxt = S_DONE;
        end else begin
          cmd.mem_op   = MEM_RD;
          cmd.addr_sel = A_ROOT_I2;
          state_nxt    = S_EV2;
        end
      end
      S_EV2: begin
        if (sts.e_valid) begin
          if (!sts.e_ok) begin
            code_nxt  = ST_OUTSIDE;
            state_nxt = S_DONE;
          end else begin
            cmd.mid_from_entry = 1'b1;
            state_nxt          = S_RD1;
          end
        end else if (!sts.free_ge2) begin
          code_nxt  = ST_EXHAUSTED;
          state_nxt = S_DONE;
        end else begin
          cmd.sweep_clr = 1'b1;
          state_nxt     = S_ZMID;
        end
      end
      S_RD1: begin
        cmd.mem_op   = MEM_RD;
        cmd.addr_sel = A_MID_I1;
        state_nxt    = S_EV1;
      end
      S_EV1: begin
        if (sts.e_valid) begin
          if (!sts.e_ok) begin
            code_nxt  = ST_OUTSIDE;
            state_nxt = S_DONE;
          end else begin
            cmd.low_from_entry = 1'b1;
            state_nxt          = S_LEAF;
          end
        end else if (sts.pool_full) begin
          code_nxt  = ST_EXHAUSTED;
          state_nxt = S_DONE;
        end else begin
          cmd.sweep_clr = 1'b1;
          state_nxt     = S_ZLOW;
        end
      end
      S_ZMID: begin
        cmd.mem_op    = MEM_WR;
        cmd.addr_sel  = A_SWEEP;
        cmd.wdata_sel = W_ZERO;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) state_nxt = S_LMID;
      end
      S_LMID: begin
        cmd.mem_op     = MEM_WR;
        cmd.addr_sel   = A_ROOT_I2;
        cmd.wdata_sel  = W_PTR;
        cmd.mid_new    = 1'b1;
        cmd.page_alloc = 1'b1;
        cmd.sweep_clr  = 1'b1;
        state_nxt      = S_ZLOW;
      end
      S_ZLOW: begin
        cmd.mem_op    = MEM_WR;
        cmd.addr_sel  = A_SWEEP;
        cmd.wdata_sel = W_ZERO;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) state_nxt = S_LLOW;
      end
      S_LLOW: begin
        cmd.mem_op     = MEM_WR;
        cmd.addr_sel   = A_MID_I1;
        cmd.wdata_sel  = W_PTR;
        cmd.low_new    = 1'b1;
        cmd.page_alloc = 1'b1;
        state_nxt      = S_LEAF;
      end
      S_LEAF: begin
        cmd.mem_op    = MEM_WR;
        cmd.addr_sel  = A_LOW_I0;
        cmd.wdata_sel = W_LEAF;
        code_nxt      = ST_OK;
        state_nxt     = S_DONE;
      end
      S_CZERO: begin
        cmd.mem_op    = MEM_WR;
        cmd.addr_sel  = A_SWEEP;
        cmd.wdata_sel = W_ZERO;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) state_nxt = S_CDEV;
      end
      S_CDEV: begin
        cmd.mem_op    = MEM_WR;
        cmd.addr_sel  = A_DEV;
        cmd.wdata_sel = W_DEV;
        state_nxt     = S_CRAM;
      end
      S_CRAM: begin
        cmd.mem_op     = MEM_WR;
        cmd.addr_sel   = A_RAM;
        cmd.wdata_sel  = W_RAM;
        cmd.low_new    = 1'b1;
        cmd.page_alloc = 1'b1;
        code_nxt       = ST_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // only the walk states may touch the table memory
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> cmd.mem_op == MEM_NONE)
    else $error("table memory accessed outside a walk");

  a_done_code_known: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> (code_r == ST_OK || code_r == ST_EXHAUSTED
                           || code_r == ST_OUTSIDE))
    else $error("result code unset on completion");

  a_sweep_enter_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ZLOW && state_nxt == S_ZLOW) |-> cmd.sweep_clr)
    else $error("page zeroing started without clearing the sweep counter");

endmodule

`default_nettype wire

// ===== sv/stb_dpath.sv =====
// table memory, page allocator, walk registers and result register
`default_nettype none

module stb_dpath
  import stb_pkg::*;
#(
  parameter int unsigned POOL_PAGES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [PPN_W-1:0] cfg_wdata,
  input  wire item_t            item,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               out_res
);

  localparam int unsigned PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned CW    = $clog2(POOL_PAGES + 1);
  localparam int unsigned AW    = PW + IDX_W;
  localparam int unsigned DEPTH = POOL_PAGES * (2 ** IDX_W);
  localparam int unsigned RW    = (CW > 4) ? CW : 4;
  localparam int unsigned QW    = (PW > 4) ? PW : 4;
  localparam int unsigned UW    = (CW > 5) ? CW : 5;

  logic [PPN_W-1:0]   base_r;
  logic [CW-1:0]      count_r;
  logic               func_r;
  logic [3:0]         root_r;
  logic [VA_W-1:0]    va_r;
  logic [PPN_W-1:0]   tppn_r;
  logic [FLAGS_W-1:0] flags_r;
  logic [PW-1:0]      mid_r;
  logic [PW-1:0]      low_r;
  logic [IDX_W-1:0]   sweep_r;
  logic [PTE_W-1:0]   rdata_r;
  logic               out_valid_r;
  result_t            out_res_r;

  logic [PTE_W-1:0]   mem [DEPTH];

  logic [RW-1:0]      root_ext;
  logic [RW-1:0]      count_ext;
  logic [PW-1:0]      root_pg;
  logic [PW-1:0]      new_pg;
  logic [IDX_W-1:0]   i2, i1, i0;
  logic [AW-1:0]      addr;
  logic [PTE_W-1:0]   wdata;
  logic [PPN_W-1:0]   new_ppn;
  logic [PPN_W-1:0]   e_ppn;
  logic [PPN_W-1:0]   e_off;
  logic               e_ok;
  logic [QW-1:0]      low_ext;
  logic [UW-1:0]      used_ext;

  assign root_ext  = RW'(root_r);
  assign count_ext = RW'(count_r);
  assign root_pg   = root_ext[PW-1:0];
  assign new_pg    = count_r[PW-1:0];
  assign i2        = va_r[38:30];
  assign i1        = va_r[29:21];
  assign i0        = va_r[20:12];
  assign new_ppn   = base_r + PPN_W'(count_r);

  // resolve the entry just read back to a page already handed out
  assign e_ppn = rdata_r[PPN_W+FLAGS_W-1:FLAGS_W];
  assign e_off = e_ppn - base_r;
  assign e_ok  = (e_ppn >= base_r) && (e_off < PPN_W'(count_r));

  always_comb begin
    unique case (cmd.addr_sel)
      A_ROOT_I2: addr = {root_pg, i2};
      A_MID_I1:  addr = {mid_r, i1};
      A_LOW_I0:  addr = {low_r, i0};
      A_SWEEP:   addr = {new_pg, sweep_r};
      A_DEV:     addr = {new_pg, DEV_SLOT};
      A_RAM:     addr = {new_pg, RAM_SLOT};
      default:   addr = {new_pg, sweep_r};
    endcase
  end

  always_comb begin
    unique case (cmd.wdata_sel)
      W_ZERO:  wdata = '0;
      W_PTR:   wdata = {10'd0, new_ppn, PTR_FLAGS};
      W_LEAF:  wdata = {10'd0, tppn_r, flags_r};
      W_DEV:   wdata = DEV_GIG_PTE;
      W_RAM:   wdata = RAM_GIG_PTE;
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_op == MEM_WR) mem[addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_op == MEM_RD) rdata_r <= mem[addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_PPN_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) base_r <= cfg_wdata;
      if (cmd.page_alloc) count_r <= count_r + CW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign low_ext  = QW'(low_r);
  assign used_ext = UW'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r  <= item.func;
      root_r  <= item.root_page;
      va_r    <= item.virt_addr;
      tppn_r  <= item.target_ppn;
      flags_r <= item.leaf_flags;
    end
    if (cmd.sweep_clr) sweep_r <= '0;
    else if (cmd.sweep_inc) sweep_r <= sweep_r + IDX_W'(1);
    if (cmd.mid_from_entry) mid_r <= e_off[PW-1:0];
    else if (cmd.mid_new) mid_r <= new_pg;
    if (cmd.low_from_entry) low_r <= e_off[PW-1:0];
    else if (cmd.low_new) low_r <= new_pg;
    if (cmd.out_load) begin
      out_res_r.status     <= cmd.out_status;
      out_res_r.page_index <= (cmd.out_status == ST_OK) ? low_ext[3:0] : 4'd0;
      out_res_r.pages_used <= used_ext[4:0];
    end
  end

  assign sts.func       = func_r;
  assign sts.root_ok    = root_ext < count_ext;
  assign sts.pool_full  = count_r >= CW'(POOL_PAGES);
  assign sts.free_ge2   = count_r < CW'(POOL_PAGES - 1);
  assign sts.e_valid    = rdata_r[0];
  assign sts.e_ok       = e_ok;
  assign sts.sweep_last = &sweep_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(POOL_PAGES))
    else $error("page count beyond pool size");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.page_alloc |=> count_r == $past(count_r) + CW'(1))
    else $error("page count did not advance on allocation");

  a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_OK) |-> out_res_r.page_index == 4'd0)
    else $error("failed result carries a page index");

endmodule

`default_nettype wire

// ===== sv/sv39_table_builder.sv =====
// Sv39 page table builder: top level joining controller and datapath.
// Each request is handled alone. A create request zeroes a fresh pool page, one entry
// per cycle through the single table memory port, and writes its two gigabyte leaves. A
// map request does one registered read per upper level when both levels are present; a
// missing level-1 table adds the zeroing of a fresh page plus the pointer write, and a
// missing level-2 entry needs two new tables and skips the level-1 read. A finished
// request waits in its last state while the output register still holds an untaken
// result. The table memory has no reset: every page is zeroed when it is taken, and
// pool_base_ppn may be changed through the cfg port only while no request is in flight.
// A result may wait in the output register while the next request is accepted.
`default_nettype none

module sv39_table_builder
  import stb_pkg::*;
#(
  parameter int unsigned POOL_PAGES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [PPN_W-1:0] cfg_wdata,
  stb_req_if.sink               in_ch,
  stb_rsp_if.source             out_ch
);

  cmd_t    cmd;
  sts_t    sts;
  item_t   item;
  result_t res;
  logic    ready;
  logic    out_valid;

  assign item.func       = in_ch.func;
  assign item.root_page  = in_ch.root_page;
  assign item.virt_addr  = in_ch.virt_addr;
  assign item.target_ppn = in_ch.target_ppn;
  assign item.leaf_flags = in_ch.leaf_flags;
  assign in_ch.ready     = ready;

  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stb_dpath #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.status     = res.status;
  assign out_ch.page_index = res.page_index;
  assign out_ch.pages_used = res.pages_used;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the sv39 table builder: directed table, then random walks against a pool mirror
`timescale 1ns / 100ps

module tb;
  import stb_pkg::*;

  localparam int unsigned POOL_PAGES = 16;
  localparam int unsigned SLOTS      = 512;
  localparam logic        FN_CREATE  = 1'b0;
  localparam logic        FN_MAP     = 1'b1;
  localparam logic [9:0]  PTR_BITS   = 10'h001;
  // gigabyte leaves for the device region at va 0 and for ram at va 0x80000000
  localparam int unsigned DEV_IDX    = 0;
  localparam int unsigned RAM_IDX    = 32'h8000_0000 >> 30;
  localparam logic [63:0] DEV_LEAF   = 64'h0000_0000_0000_00CF;
  localparam logic [63:0] RAM_LEAF   = ((64'h8000_0000 >> 12) << 10) | 64'hCF;
  localparam int unsigned PHASE_ITEMS = 60;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [PPN_W-1:0] cfg_wdata;

  stb_req_if req_ch ();
  stb_rsp_if rsp_ch ();

  sv39_table_builder #(.POOL_PAGES(POOL_PAGES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch)
  );

  // mirror of the pool and the page counter
  logic [63:0]      table_mirror [0:POOL_PAGES*SLOTS-1];
  int unsigned      pool_fill;
  logic [PPN_W-1:0] pool_base;

  result_t  due_results [$];
  dir_row_t dir_rows [$];
  int       mismatch_count;
  int       long_hold_left;
  int       stall_left;
  bit       calm;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned claim_page();
    int unsigned p;
    p = pool_fill;
    for (int k = 0; k < SLOTS; k++) table_mirror[p*SLOTS + k] = '0;
    pool_fill = p + 1;
    return p;
  endfunction

  function automatic int unsigned hang_new_table(int unsigned at);
    int unsigned      p;
    logic [PPN_W-1:0] ppn;
    p = claim_page();
    ppn = pool_base + PPN_W'(p);
    table_mirror[at] = {10'b0, ppn, PTR_BITS};
    return p;
  endfunction

  // valid entry to a handed-out pool page, leaf or not
  function automatic bit follow_entry(logic [63:0] e, output int unsigned pg);
    logic [PPN_W-1:0] ppn;
    logic [PPN_W-1:0] off;
    pg = 0;
    ppn = e[53:10];
    if (ppn < pool_base) return 1'b0;
    off = ppn - pool_base;
    if (off >= PPN_W'(pool_fill)) return 1'b0;
    pg = int'(off);
    return 1'b1;
  endfunction

  function automatic result_t predict_tables(item_t it);
    result_t     r;
    status_t     st;
    int unsigned root, page, mid, low, need;
    bit          mid_ok, low_ok;
    logic [8:0]  i2, i1, i0;
    logic [63:0] e;
    st = ST_OK;
    page = 0;
    mid = 0;
    low = 0;
    need = 0;
    mid_ok = 1'b0;
    low_ok = 1'b0;
    root = it.root_page;
    i2 = it.virt_addr[38:30];
    i1 = it.virt_addr[29:21];
    i0 = it.virt_addr[20:12];
    if (it.func == FN_CREATE) begin
      if (pool_fill >= POOL_PAGES) begin
        st = ST_EXHAUSTED;
      end else begin
        page = claim_page();
        table_mirror[page*SLOTS + DEV_IDX] = DEV_LEAF;
        table_mirror[page*SLOTS + RAM_IDX] = RAM_LEAF;
      end
    end else if (root >= pool_fill) begin
      st = ST_OUTSIDE;
    end else begin
      e = table_mirror[root*SLOTS + i2];
      if (!e[0]) begin
        need = 2;
      end else if (!follow_entry(e, mid)) begin
        st = ST_OUTSIDE;
      end else begin
        mid_ok = 1'b1;
        e = table_mirror[mid*SLOTS + i1];
        if (!e[0]) need = 1;
        else if (!follow_entry(e, low)) st = ST_OUTSIDE;
        else low_ok = 1'b1;
      end
      // a bad pointer is reported ahead of a short pool
      if (st == ST_OK && need > POOL_PAGES - pool_fill) st = ST_EXHAUSTED;
      if (st == ST_OK) begin
        if (!mid_ok) mid = hang_new_table(root*SLOTS + i2);
        if (!low_ok) low = hang_new_table(mid*SLOTS + i1);
        table_mirror[low*SLOTS + i0] = {10'b0, it.target_ppn, it.leaf_flags};
        page = low;
      end
    end
    r.status     = st;
    r.page_index = page[3:0];
    r.pages_used = pool_fill[4:0];
    return r;
  endfunction

  function automatic logic [8:0] pick_live_slot(int unsigned pg);
    int unsigned live [$];
    for (int k = 0; k < SLOTS; k++) begin
      if (table_mirror[pg*SLOTS + k][0] === 1'b1) live.push_back(k);
    end
    if (live.size() == 0) return 9'($urandom_range(0, SLOTS - 1));
    return 9'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // mostly walks along entries already present, so the walk gets past level 2
  function automatic item_t make_random_item();
    item_t       it;
    int unsigned root, mid;
    logic [8:0]  i2;
    logic [63:0] e;
    it = '0;
    mid = 0;
    it.func = ($urandom_range(0, 11) == 0) ? FN_CREATE : FN_MAP;
    it.root_page = 4'($urandom_range(0, 15));
    root = it.root_page;
    it.virt_addr = 39'({$urandom(), $urandom()});
    it.target_ppn = 44'({$urandom(), $urandom()});
    if ($urandom_range(0, 9) < 3)
      it.target_ppn = pool_base + 44'($urandom_range(0, POOL_PAGES + 1));
    it.leaf_flags = 10'($urandom());
    if (root < pool_fill && $urandom_range(0, 9) < 7) begin
      i2 = pick_live_slot(root);
      it.virt_addr[38:30] = i2;
      e = table_mirror[root*SLOTS + i2];
      if (e[0] === 1'b1 && follow_entry(e, mid) && $urandom_range(0, 9) < 7) begin
        it.virt_addr[29:21] = pick_live_slot(mid);
      end
    end
    return it;
  endfunction

  function automatic logic [38:0] va_at(int unsigned i2, int unsigned i1, int unsigned i0);
    return {9'(i2), 9'(i1), 9'(i0), 12'h000};
  endfunction

  function automatic void add_row(logic fn, logic [3:0] root, logic [38:0] va,
                                  logic [43:0] tppn, logic [9:0] flags, bit typed = 1'b0,
                                  status_t st = ST_OK, logic [3:0] pg = 4'd0,
                                  logic [4:0] used = 5'd0);
    dir_row_t row;
    row.stim.func       = fn;
    row.stim.root_page  = root;
    row.stim.virt_addr  = va;
    row.stim.target_ppn = tppn;
    row.stim.leaf_flags = flags;
    row.typed           = typed;
    row.want.status     = st;
    row.want.page_index = pg;
    row.want.pages_used = used;
    dir_rows.push_back(row);
  endfunction

  task automatic offer(item_t it, bit typed, result_t want);
    result_t guess;
    if (!calm && long_hold_left == 0 && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= it.func;
    req_ch.root_page  <= it.root_page;
    req_ch.virt_addr  <= it.virt_addr;
    req_ch.target_ppn <= it.target_ppn;
    req_ch.leaf_flags <= it.leaf_flags;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    guess = predict_tables(it);
    due_results.push_back(typed ? want : guess);
  endtask

  task automatic set_pool_base(logic [PPN_W-1:0] v);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pool_base  = v;
  endtask

  task automatic take_result();
    result_t got, want;
    got.status     = rsp_ch.status;
    got.page_index = rsp_ch.page_index;
    got.pages_used = rsp_ch.pages_used;
    if (due_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result with nothing outstanding: status %0d page %0d used %0d",
                 got.status, got.page_index, got.pages_used);
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status || got.page_index !== want.page_index ||
          got.pages_used !== want.pages_used) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected status %0d page %0d used %0d, got %0d %0d %0d",
                   want.status, want.page_index, want.pages_used,
                   got.status, got.page_index, got.pages_used);
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off counted here
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) take_result();
      if (long_hold_left > 0) begin
        long_hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [PPN_W-1:0] phase_base [6];
    item_t            it;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.func       = 1'b0;
    req_ch.root_page  = '0;
    req_ch.virt_addr  = '0;
    req_ch.target_ppn = '0;
    req_ch.leaf_flags = '0;
    mismatch_count    = 0;
    long_hold_left    = 0;
    stall_left        = 0;
    calm              = 1'b0;
    pool_fill         = 0;
    pool_base         = BASE_PPN_RESET;

    phase_base[0] = BASE_PPN_RESET;
    phase_base[1] = '1;
    phase_base[2] = '0;
    phase_base[3] = BASE_PPN_RESET - 44'd1;
    phase_base[4] = 44'({$urandom(), $urandom()});
    phase_base[5] = BASE_PPN_RESET;

    // no root handed out yet
    add_row(FN_MAP, 4'd0, 39'd0, 44'd0, 10'd0, 1, ST_OUTSIDE, 4'd0, 5'd0);
    // create ignores the map fields
    add_row(FN_CREATE, 4'hF, '1, '1, '1, 1, ST_OK, 4'd0, 5'd1);
    // device gigabyte leaf points below the pool
    add_row(FN_MAP, 4'd0, va_at(0, 0, 0), 44'd0, 10'd0, 1, ST_OUTSIDE, 4'd0, 5'd1);
    // ram leaf followed into page 0, then device leaf at level 1 is outside
    add_row(FN_MAP, 4'd0, va_at(2, 0, 0), 44'd0, 10'd0, 1, ST_OUTSIDE, 4'd0, 5'd1);
    add_row(FN_MAP, 4'd0, va_at(2, 5, 7), 44'd0, 10'd0);
    add_row(FN_MAP, 4'd0, va_at(2, 2, 3), '1, '1);
    add_row(FN_MAP, 4'd0, '1, BASE_PPN_RESET, 10'h001);
    add_row(FN_MAP, 4'hF, va_at(1, 1, 1), 44'd5, 10'd5, 1, ST_OUTSIDE, 4'd0, 5'd4);
    add_row(FN_MAP, 4'd4, va_at(1, 1, 1), 44'd5, 10'd5, 1, ST_OUTSIDE, 4'd0, 5'd4);
    add_row(FN_MAP, 4'd3, va_at(511, 5, 9), 44'h12345, 10'h0FF);
    // all-ones leaf written above now reads as a pointer far outside
    add_row(FN_MAP, 4'd0, va_at(2, 3, 0), 44'd1, 10'd1, 1, ST_OUTSIDE, 4'd0, 5'd4);
    add_row(FN_CREATE, 4'd0, 39'd0, 44'd0, 10'd0, 1, ST_OK, 4'd4, 5'd5);
    add_row(FN_MAP, 4'd4, va_at(1, 1, 1), 44'hABCDE, 10'h2AA);
    add_row(FN_CREATE, 4'd0, 39'd0, 44'd0, 10'd0, 1, ST_OK, 4'd7, 5'd8);
    add_row(FN_MAP, 4'd7, va_at(300, 10, 20), 44'h155, 10'h155);
    add_row(FN_MAP, 4'd7, va_at(300, 11, 21), 44'h2AA, 10'h0C3);
    add_row(FN_CREATE, 4'd0, 39'd0, 44'd0, 10'd0, 1, ST_OK, 4'd11, 5'd12);
    add_row(FN_CREATE, 4'd0, 39'd0, 44'd0, 10'd0, 1, ST_OK, 4'd12, 5'd13);
    add_row(FN_MAP, 4'd12, va_at(5, 1, 2), 44'h77, 10'h0F);
    // two tables needed, one page left
    add_row(FN_MAP, 4'd12, va_at(6, 0, 0), 44'd0, 10'd0, 1, ST_EXHAUSTED, 4'd0, 5'd15);
    add_row(FN_MAP, 4'd12, va_at(5, 2, 3), 44'h88, 10'h11);
    add_row(FN_CREATE, 4'd0, 39'd0, 44'd0, 10'd0, 1, ST_EXHAUSTED, 4'd0, 5'd16);
    add_row(FN_MAP, 4'd12, va_at(5, 3, 4), 44'd0, 10'd0, 1, ST_EXHAUSTED, 4'd0, 5'd16);
    add_row(FN_MAP, 4'd12, va_at(5, 2, 8), 44'h99, 10'h3FF);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) offer(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);
    req_ch.valid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      set_pool_base(phase_base[ph]);
      // fill the block up while results are held back
      if (ph == 0) long_hold_left = 300;
      if (ph == 5) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) begin
          req_ch.valid <= 1'b0;
          do @(posedge clk); while (due_results.size() != 0);
        end
        it = make_random_item();
        offer(it, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
    end

    do @(posedge clk); while (due_results.size() != 0);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
